// ===== hdl/wpmt_pkg.sv =====
// ----------------------------------------------------------------------------
// wpmt_pkg: shared types and constants
// Action codes, key widths and the probe token passed along the cell chain.
// ----------------------------------------------------------------------------
package wpmt_pkg;

    localparam logic [1:0] ACT_REGISTER = 2'd0;
    localparam logic [1:0] ACT_PROBE    = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;
    localparam logic [1:0] ACT_READ     = 2'd3;

    localparam int unsigned CFG_WILDCARD_WIDE   = 0;
    localparam int unsigned CFG_WILDCARD_NARROW = 1;

    localparam int unsigned RANK_W = 16;

    // Device context searched against the table.
    typedef struct packed {
        logic [1:0]  bus_kind;
        logic [15:0] vendor;
        logic [15:0] device;
        logic [7:0]  dev_class;
        logic [7:0]  subclass;
        logic [7:0]  prog_if;
    } key_t;

    // Stored descriptor.
    typedef struct packed {
        key_t       key;
        logic [7:0] prio;
    } desc_t;

    // Running best match carried from cell to cell.
    typedef struct packed {
        logic              have;
        logic [7:0]        best;
        logic [RANK_W-1:0] rank;
    } best_t;

endpackage

// ===== hdl/wpmt_if.sv =====
// ----------------------------------------------------------------------------
// wpmt_in_if / wpmt_out_if: valid/ready channels
// Input request beats and result beats of the classifier table.
// ----------------------------------------------------------------------------
interface wpmt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [1:0]  bus_kind;
    logic [15:0] vendor;
    logic [15:0] device;
    logic [7:0]  dev_class;
    logic [7:0]  subclass;
    logic [7:0]  prog_if;
    logic [7:0]  priority_req;
    logic [7:0]  pci_bus;
    logic [4:0]  slot_num;
    logic [2:0]  func_num;
    logic [6:0]  binding_index;
    modport source (output valid, action, bus_kind, vendor, device, dev_class,
                    subclass, prog_if, priority_req, pci_bus, slot_num, func_num,
                    binding_index, input ready);
    modport sink (input valid, action, bus_kind, vendor, device, dev_class,
                  subclass, prog_if, priority_req, pci_bus, slot_num, func_num,
                  binding_index, output ready);
endinterface

interface wpmt_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [5:0]  descriptor_index;
    logic [7:0]  bind_count;
    logic [1:0]  found_bus_kind;
    logic [15:0] found_vendor;
    logic [15:0] found_device;
    logic [7:0]  found_dev_class;
    logic [7:0]  found_subclass;
    logic [7:0]  found_prog_if;
    logic [7:0]  found_pci_bus;
    logic [4:0]  found_slot_num;
    logic [2:0]  found_func_num;
    modport source (output valid, accepted, descriptor_index, bind_count,
                    found_bus_kind, found_vendor, found_device, found_dev_class,
                    found_subclass, found_prog_if, found_pci_bus, found_slot_num,
                    found_func_num, input ready);
    modport sink (input valid, accepted, descriptor_index, bind_count,
                  found_bus_kind, found_vendor, found_device, found_dev_class,
                  found_subclass, found_prog_if, found_pci_bus, found_slot_num,
                  found_func_num, output ready);
endinterface

// ===== hdl/wpmt_cell.sv =====
// ----------------------------------------------------------------------------
// wpmt_cell: one descriptor slot of the match chain
// Holds one descriptor and its valid flag; each cycle it compares the probe
// key arriving from its left neighbor and forwards the key and the updated
// best match to its right neighbor.
// ----------------------------------------------------------------------------
module wpmt_cell
    import wpmt_pkg::*;
#(
    parameter int unsigned INDEX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clr,
    input  logic        wr_en,
    input  desc_t       wr_desc,
    input  logic [15:0] wc_wide,
    input  logic [7:0]  wc_narrow,
    input  logic        tok_valid_in,
    input  key_t        key_in,
    input  best_t       best_in,
    output logic        tok_valid_out,
    output key_t        key_out,
    output best_t       best_out
);

    logic  used_reg;
    desc_t desc_reg;
    logic  hit;
    logic  wv, wd, wc, ws, wp;
    logic [2:0] spec;
    logic [RANK_W-1:0] rank;
    best_t best_next;

    // Descriptor storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (clr)
        begin
            used_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            used_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            desc_reg <= wr_desc;
        end
    end

    // Wildcard compare and rank of this slot.
    always_comb
    begin
        wv = (desc_reg.key.vendor == wc_wide);
        wd = (desc_reg.key.device == wc_wide);
        wc = (desc_reg.key.dev_class == wc_narrow);
        ws = (desc_reg.key.subclass == wc_narrow);
        wp = (desc_reg.key.prog_if == wc_narrow);
        hit = used_reg && (desc_reg.key.bus_kind == key_in.bus_kind)
            && (wv || desc_reg.key.vendor == key_in.vendor)
            && (wd || desc_reg.key.device == key_in.device)
            && (wc || desc_reg.key.dev_class == key_in.dev_class)
            && (ws || desc_reg.key.subclass == key_in.subclass)
            && (wp || desc_reg.key.prog_if == key_in.prog_if);
        spec = 3'({2'b0, !wv} + {2'b0, !wd} + {2'b0, !wc} + {2'b0, !ws} + {2'b0, !wp});
        rank = {desc_reg.prio, 5'd0, spec};
        best_next = best_in;
        if (hit && (!best_in.have || rank > best_in.rank))
        begin
            best_next.have = 1'b1;
            best_next.best = 8'(INDEX);
            best_next.rank = rank;
        end
    end

    // Hand the token to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_out <= 1'b0;
        end
        else
        begin
            tok_valid_out <= tok_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        key_out  <= key_in;
        best_out <= best_next;
    end

endmodule

// ===== hdl/wildcard_priority_match_table.sv =====
// ----------------------------------------------------------------------------
// wildcard_priority_match_table: wildcard classifier with binding store
// Descriptors live in a chain of match cells; bindings live in two memories.
//
//   channel  dir  beat contents
//   in       in   action, device context, priority, place, binding index
//   out      out  accepted, indexes, count, found binding fields
//   cfg      in   wildcard codes, index 0 wide and index 1 narrow
//
// During a probe the key walks one cell per cycle down the descriptor chain,
// and the binding store is written at the edge that loads the result.
// Register and clear load the result at acceptance; a read passes through the
// address register, the memory output register and the result register.
// One item is in flight at a time; in.ready returns in the cycle after the
// result beat is taken, and result stalls hold off further requests. No
// clearing pass runs after reset.
// ----------------------------------------------------------------------------
module wildcard_priority_match_table
    import wpmt_pkg::*;
#(
    parameter int unsigned DESCRIPTOR_DEPTH = 64,
    parameter int unsigned BINDING_DEPTH    = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    wpmt_in_if.sink     in,
    wpmt_out_if.source  out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int unsigned DCW = $clog2(DESCRIPTOR_DEPTH + 1);
    localparam int unsigned BCW = $clog2(BINDING_DEPTH + 1);
    localparam int unsigned BAW = (BINDING_DEPTH > 1) ? $clog2(BINDING_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_RDATA = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]     state_reg;
    logic [15:0]    wc_wide_reg;
    logic [7:0]     wc_narrow_reg;
    logic [DCW-1:0] dused_reg;
    logic [BCW-1:0] bused_reg;
    key_t           ctx_reg;
    logic [7:0]     pbus_reg;
    logic [4:0]     pslot_reg;
    logic [2:0]     pfn_reg;

    // Binding memories.
    logic [41:0] bid_mem [BINDING_DEPTH];
    logic [39:0] bpl_mem [BINDING_DEPTH];
    logic [41:0] bid_rd_reg;
    logic [39:0] bpl_rd_reg;
    logic        bmem_we;
    logic [BAW-1:0] bmem_wa;
    logic [BAW-1:0] rd_addr_reg;
    logic [41:0] bid_wd;
    logic [39:0] bpl_wd;

    // Chain wiring.
    logic  tv   [DESCRIPTOR_DEPTH+1];
    key_t  tkey [DESCRIPTOR_DEPTH+1];
    best_t tbst [DESCRIPTOR_DEPTH+1];
    desc_t wr_desc;
    logic  in_fire, out_fire, wr_desc_en;

    assign in_fire  = in.valid && in.ready;
    assign out_fire = out.valid && out.ready;
    assign in.ready = (state_reg == ST_IDLE);
    assign out.valid = (state_reg == ST_OUT);

    assign wr_desc.key.bus_kind   = in.bus_kind;
    assign wr_desc.key.vendor     = in.vendor;
    assign wr_desc.key.device     = in.device;
    assign wr_desc.key.dev_class  = in.dev_class;
    assign wr_desc.key.subclass   = in.subclass;
    assign wr_desc.key.prog_if    = in.prog_if;
    assign wr_desc.prio           = in.priority_req;
    assign wr_desc_en = in_fire && (in.action == ACT_REGISTER)
                        && (dused_reg < DCW'(DESCRIPTOR_DEPTH));

    assign tv[0]   = in_fire && (in.action == ACT_PROBE);
    assign tkey[0] = wr_desc.key;
    assign tbst[0] = '0;

    // Descriptor cell chain.
    for (genvar i = 0; i < DESCRIPTOR_DEPTH; i++)
    begin : g_cell
        wpmt_cell #(.INDEX(i)) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .clr          (1'b0),
            .wr_en        (wr_desc_en && (dused_reg == DCW'(i))),
            .wr_desc      (wr_desc),
            .wc_wide      (wc_wide_reg),
            .wc_narrow    (wc_narrow_reg),
            .tok_valid_in (tv[i]),
            .key_in       (tkey[i]),
            .best_in      (tbst[i]),
            .tok_valid_out(tv[i+1]),
            .key_out      (tkey[i+1]),
            .best_out     (tbst[i+1])
        );
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_wide_reg   <= 16'hFFFF;
            wc_narrow_reg <= 8'hFF;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'(CFG_WILDCARD_WIDE))
                wc_wide_reg <= cfg_data;
            else
                wc_narrow_reg <= cfg_data[7:0];
        end
    end

    // Binding write at the end of a probe.
    assign bmem_we = tv[DESCRIPTOR_DEPTH] && tbst[DESCRIPTOR_DEPTH].have
                     && (bused_reg < BCW'(BINDING_DEPTH));
    assign bmem_wa = BAW'(bused_reg);
    assign bid_wd = {tbst[DESCRIPTOR_DEPTH].best, ctx_reg.device,
                     ctx_reg.vendor, ctx_reg.bus_kind};
    assign bpl_wd = {pfn_reg, pslot_reg, pbus_reg, ctx_reg.prog_if,
                     ctx_reg.subclass, ctx_reg.dev_class};

    always_ff @(posedge clk)
    begin
        if (bmem_we)
        begin
            bid_mem[bmem_wa] <= bid_wd;
            bpl_mem[bmem_wa] <= bpl_wd;
        end
        bid_rd_reg <= bid_mem[rd_addr_reg];
        bpl_rd_reg <= bpl_mem[rd_addr_reg];
    end

    // Sequencer and occupancy counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dused_reg <= '0;
            bused_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (in.action)
                            ACT_REGISTER:
                            begin
                                if (wr_desc_en)
                                    dused_reg <= dused_reg + 1'b1;
                                state_reg <= ST_OUT;
                            end
                            ACT_PROBE: state_reg <= ST_SCAN;
                            ACT_CLEAR:
                            begin
                                bused_reg <= '0;
                                state_reg <= ST_OUT;
                            end
                            default: state_reg <= ST_READ;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (tv[DESCRIPTOR_DEPTH])
                    begin
                        if (bmem_we)
                            bused_reg <= bused_reg + 1'b1;
                        state_reg <= ST_OUT;
                    end
                end
                ST_READ:  state_reg <= ST_RDATA;
                ST_RDATA: state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_fire)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Result payload.
    logic rd_ok_reg;
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ctx_reg      <= wr_desc.key;
            pbus_reg     <= in.pci_bus;
            pslot_reg    <= in.slot_num;
            pfn_reg      <= in.func_num;
            rd_addr_reg  <= BAW'(in.binding_index);
            rd_ok_reg    <= (32'(in.binding_index) < 32'(bused_reg))
                            && (int'(in.binding_index) < BINDING_DEPTH);
            out.accepted <= (in.action == ACT_CLEAR) || wr_desc_en;
            out.descriptor_index <= wr_desc_en ? 6'(dused_reg) : 6'd0;
            {out.found_func_num, out.found_slot_num, out.found_pci_bus,
             out.found_prog_if, out.found_subclass, out.found_dev_class} <= '0;
            {out.found_device, out.found_vendor, out.found_bus_kind} <= '0;
            out.bind_count <= (in.action == ACT_CLEAR) ? 8'd0 : 8'(bused_reg);
        end
        else if (state_reg == ST_SCAN && tv[DESCRIPTOR_DEPTH])
        begin
            out.accepted <= bmem_we;
            out.bind_count <= 8'(bused_reg + BCW'(bmem_we));
            if (bmem_we)
            begin
                out.descriptor_index <= 6'(bid_wd[41:34]);
                {out.found_device, out.found_vendor, out.found_bus_kind} <=
                    bid_wd[33:0];
                {out.found_func_num, out.found_slot_num, out.found_pci_bus,
                 out.found_prog_if, out.found_subclass, out.found_dev_class} <= bpl_wd;
            end
        end
        else if (state_reg == ST_RDATA)
        begin
            out.accepted <= rd_ok_reg;
            if (rd_ok_reg)
            begin
                out.descriptor_index <= 6'(bid_rd_reg[41:34]);
                {out.found_device, out.found_vendor, out.found_bus_kind} <=
                    bid_rd_reg[33:0];
                {out.found_func_num, out.found_slot_num, out.found_pci_bus,
                 out.found_prog_if, out.found_subclass, out.found_dev_class} <= bpl_rd_reg;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bused_reg <= BCW'(BINDING_DEPTH))
        else $error("binding count beyond depth");
    a_desc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dused_reg <= DCW'(DESCRIPTOR_DEPTH))
        else $error("descriptor count beyond depth");
    a_tok_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tv[DESCRIPTOR_DEPTH] |-> state_reg == ST_SCAN)
        else $error("probe token outside scan");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid && $stable(out.accepted))
        else $error("result changed while stalled");
`endif

endmodule

// ===== dv/wpmt_checker.sv =====
// ----------------------------------------------------------------------------
// wpmt_checker: result predictor and comparator
// Watches the request and result channels of the classifier table, keeps its
// own copy of the descriptor table and binding store, and checks each result
// beat against the oldest predicted result.
// ----------------------------------------------------------------------------
module wpmt_checker
    import wpmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    wpmt_in_if.sink     in_mon,
    wpmt_out_if.sink    out_mon,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    localparam int unsigned DESC_MAX = 64;
    localparam int unsigned BIND_MAX = 128;

    typedef struct packed {
        logic        accepted;
        logic [5:0]  descriptor_index;
        logic [7:0]  bind_count;
        logic [1:0]  bus_kind;
        logic [15:0] vendor;
        logic [15:0] device;
        logic [7:0]  dev_class;
        logic [7:0]  subclass;
        logic [7:0]  prog_if;
        logic [7:0]  pci_bus;
        logic [4:0]  slot_num;
        logic [2:0]  func_num;
    } outcome_t;

    typedef struct packed {
        logic [5:0]  desc_idx;
        key_t        ctx;
        logic [7:0]  pci_bus;
        logic [4:0]  slot_num;
        logic [2:0]  func_num;
    } binding_t;

    logic [15:0] wild_wide;
    logic [7:0]  wild_narrow;
    desc_t       desc_table [DESC_MAX];
    int unsigned desc_used;
    binding_t    bind_store [BIND_MAX];
    int unsigned bind_used;
    outcome_t    expected_outcomes [$];

    assign pending_count = expected_outcomes.size();

    function automatic outcome_t from_binding(binding_t b);
        outcome_t o;
        o = '0;
        o.accepted = 1'b1;
        o.descriptor_index = b.desc_idx;
        o.bus_kind = b.ctx.bus_kind;
        o.vendor = b.ctx.vendor;
        o.device = b.ctx.device;
        o.dev_class = b.ctx.dev_class;
        o.subclass = b.ctx.subclass;
        o.prog_if = b.ctx.prog_if;
        o.pci_bus = b.pci_bus;
        o.slot_num = b.slot_num;
        o.func_num = b.func_num;
        return o;
    endfunction

    // Apply one request beat to the shadow state and return its result.
    function automatic outcome_t classify(key_t ctx, logic [1:0] act, logic [7:0] prio,
                                          logic [7:0] pbus, logic [4:0] pslot,
                                          logic [2:0] pfn, logic [6:0] bidx);
        outcome_t o;
        binding_t b;
        key_t k;
        bit have;
        int unsigned best, top_rank, spec, rank;
        o = '0;
        have = 0;
        best = 0;
        top_rank = 0;
        case (act)
            ACT_REGISTER:
            begin
                if (desc_used < DESC_MAX)
                begin
                    desc_table[desc_used] = '{key: ctx, prio: prio};
                    o.accepted = 1'b1;
                    o.descriptor_index = desc_used[5:0];
                    desc_used++;
                end
            end
            ACT_PROBE:
            begin
                for (int d = 0; d < desc_used; d++)
                begin
                    k = desc_table[d].key;
                    if (k.bus_kind != ctx.bus_kind) continue;
                    if (k.vendor != wild_wide && k.vendor != ctx.vendor) continue;
                    if (k.device != wild_wide && k.device != ctx.device) continue;
                    if (k.dev_class != wild_narrow && k.dev_class != ctx.dev_class) continue;
                    if (k.subclass != wild_narrow && k.subclass != ctx.subclass) continue;
                    if (k.prog_if != wild_narrow && k.prog_if != ctx.prog_if) continue;
                    spec = (k.vendor != wild_wide) + (k.device != wild_wide)
                         + (k.dev_class != wild_narrow) + (k.subclass != wild_narrow)
                         + (k.prog_if != wild_narrow);
                    rank = desc_table[d].prio * 256 + spec;
                    if (!have || rank > top_rank)
                    begin
                        have = 1;
                        best = d;
                        top_rank = rank;
                    end
                end
                if (have && bind_used < BIND_MAX)
                begin
                    b = '{desc_idx: best[5:0], ctx: ctx, pci_bus: pbus,
                          slot_num: pslot, func_num: pfn};
                    bind_store[bind_used] = b;
                    bind_used++;
                    o = from_binding(b);
                end
            end
            ACT_CLEAR:
            begin
                bind_used = 0;
                o.accepted = 1'b1;
            end
            default:
            begin
                if (bidx < bind_used)
                    o = from_binding(bind_store[bidx]);
            end
        endcase
        o.bind_count = bind_used[7:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    // Sample both channels and the configuration port at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got, want;
        key_t ctx;
        if (!rst_n)
        begin
            wild_wide <= 16'hFFFF;
            wild_narrow <= 8'hFF;
            desc_used = 0;
            bind_used = 0;
            fail_count = 0;
            expected_outcomes.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WILDCARD_WIDE[0]) wild_wide <= cfg_data;
                else wild_narrow <= cfg_data[7:0];
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got = '{out_mon.accepted, out_mon.descriptor_index, out_mon.bind_count,
                        out_mon.found_bus_kind, out_mon.found_vendor,
                        out_mon.found_device, out_mon.found_dev_class,
                        out_mon.found_subclass, out_mon.found_prog_if,
                        out_mon.found_pci_bus, out_mon.found_slot_num,
                        out_mon.found_func_num};
                if (expected_outcomes.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected", 32'd1, 32'd0);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", got.accepted, want.accepted);
                    if (got.descriptor_index !== want.descriptor_index)
                        report_mismatch("descriptor_index", got.descriptor_index,
                                        want.descriptor_index);
                    if (got.bind_count !== want.bind_count)
                        report_mismatch("bind_count", got.bind_count, want.bind_count);
                    if (got.bus_kind !== want.bus_kind)
                        report_mismatch("found_bus_kind", got.bus_kind, want.bus_kind);
                    if (got.vendor !== want.vendor)
                        report_mismatch("found_vendor", got.vendor, want.vendor);
                    if (got.device !== want.device)
                        report_mismatch("found_device", got.device, want.device);
                    if (got.dev_class !== want.dev_class)
                        report_mismatch("found_dev_class", got.dev_class, want.dev_class);
                    if (got.subclass !== want.subclass)
                        report_mismatch("found_subclass", got.subclass, want.subclass);
                    if (got.prog_if !== want.prog_if)
                        report_mismatch("found_prog_if", got.prog_if, want.prog_if);
                    if (got.pci_bus !== want.pci_bus)
                        report_mismatch("found_pci_bus", got.pci_bus, want.pci_bus);
                    if (got.slot_num !== want.slot_num)
                        report_mismatch("found_slot_num", got.slot_num, want.slot_num);
                    if (got.func_num !== want.func_num)
                        report_mismatch("found_func_num", got.func_num,
                                        want.func_num);
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                ctx = '{in_mon.bus_kind, in_mon.vendor, in_mon.device,
                        in_mon.dev_class, in_mon.subclass, in_mon.prog_if};
                expected_outcomes.push_back(classify(ctx, in_mon.action, in_mon.priority_req,
                                                     in_mon.pci_bus, in_mon.slot_num,
                                                     in_mon.func_num,
                                                     in_mon.binding_index));
            end
        end
    end

endmodule

// ===== dv/tb_wildcard_priority_match_table.sv =====
// ----------------------------------------------------------------------------
// tb_wildcard_priority_match_table: classifier table testbench
// Drives directed and random register, probe, clear and read beats with
// random gaps and result stalls, sweeps the wildcard codes between phases,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_wildcard_priority_match_table;
    import wpmt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending_count;

    // Current wildcard codes, so that random keys can pick them.
    logic [15:0] cur_wide;
    logic [7:0]  cur_narrow;

    wpmt_in_if  in_ch ();
    wpmt_out_if out_ch ();

    wildcard_priority_match_table dut (
        .clk(clk), .rst_n(rst_n), .in(in_ch.sink), .out(out_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    wpmt_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Result side stalls a random number of cycles before each beat.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_WILDCARD_WIDE[0]) cur_wide = val;
        else cur_narrow = val[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // Send one request beat after a random gap.
    task automatic send_beat(logic [1:0] act, key_t k, logic [7:0] prio,
                             logic [7:0] pbus, logic [4:0] pslot, logic [2:0] pfn,
                             logic [6:0] bidx);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        // The cycle after an acceptance never accepts, so it is always waited out.
        repeat (gap + 1) @(posedge clk);
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.bus_kind <= k.bus_kind;
        in_ch.vendor <= k.vendor;
        in_ch.device <= k.device;
        in_ch.dev_class <= k.dev_class;
        in_ch.subclass <= k.subclass;
        in_ch.prog_if <= k.prog_if;
        in_ch.priority_req <= prio;
        in_ch.pci_bus <= pbus;
        in_ch.slot_num <= pslot;
        in_ch.func_num <= pfn;
        in_ch.binding_index <= bidx;
        do @(posedge clk); while (!in_ch.ready);
        in_ch.valid <= 1'b0;
    endtask

    // Key values drawn from a small pool so that probes match often.
    function automatic logic [15:0] pick_wide(bit allow_wild);
        if (allow_wild && $urandom_range(0, 2) == 0) return cur_wide;
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 3));
    endfunction

    function automatic logic [7:0] pick_narrow(bit allow_wild);
        if (allow_wild && $urandom_range(0, 2) == 0) return cur_narrow;
        if ($urandom_range(0, 7) == 0) return 8'($urandom);
        return 8'($urandom_range(0, 3));
    endfunction

    function automatic key_t pick_key(bit allow_wild);
        key_t k;
        k.bus_kind = ($urandom_range(0, 5) == 0) ? 2'($urandom) : 2'd0;
        k.vendor = pick_wide(allow_wild);
        k.device = pick_wide(allow_wild);
        k.dev_class = pick_narrow(allow_wild);
        k.subclass = pick_narrow(allow_wild);
        k.prog_if = pick_narrow(allow_wild);
        return k;
    endfunction

    task automatic random_beat();
        int sel;
        logic [1:0] act;
        sel = $urandom_range(0, 99);
        if (sel < 30) act = ACT_REGISTER;
        else if (sel < 75) act = ACT_PROBE;
        else if (sel < 80) act = ACT_CLEAR;
        else act = ACT_READ;
        send_beat(act, pick_key(act == ACT_REGISTER),
                  ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom),
                  8'($urandom), 5'($urandom), 3'($urandom),
                  ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 15)));
    endtask

    initial
    begin
        key_t k;
        logic [15:0] wide_set [4];
        logic [7:0]  narrow_set [4];
        wide_set = '{16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF};
        narrow_set = '{8'hFF, 8'h00, 8'h02, 8'h80};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        cur_wide = 16'hFFFF;
        cur_narrow = 8'hFF;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_REGISTER;
        in_ch.bus_kind = '0;
        in_ch.vendor = '0;
        in_ch.device = '0;
        in_ch.dev_class = '0;
        in_ch.subclass = '0;
        in_ch.prog_if = '0;
        in_ch.priority_req = '0;
        in_ch.pci_bus = '0;
        in_ch.slot_num = '0;
        in_ch.func_num = '0;
        in_ch.binding_index = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty probe and read, wildcard and exact keys, priority tie,
        // extremes of every field, clear.
        k = '{2'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF};
        send_beat(ACT_PROBE, k, 8'd0, 8'hFF, 5'h1F, 3'h7, 7'd0);
        send_beat(ACT_READ, k, 8'd0, 8'd0, 5'd0, 3'd0, 7'd127);
        send_beat(ACT_REGISTER, k, 8'd0, 8'd0, 5'd0, 3'd0, 7'd0);
        send_beat(ACT_REGISTER, '{2'd3, 16'h1234, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF},
                  8'd0, 8'd0, 5'd0, 3'd0, 7'd0);
        send_beat(ACT_REGISTER, '{2'd3, 16'h1234, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF},
                  8'd0, 8'd0, 5'd0, 3'd0, 7'd0);
        send_beat(ACT_REGISTER, '{2'd0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00},
                  8'hFF, 8'd0, 5'd0, 3'd0, 7'd0);
        send_beat(ACT_PROBE, '{2'd3, 16'h1234, 16'h0000, 8'h00, 8'h00, 8'h00},
                  8'd0, 8'hFF, 5'h1F, 3'h7, 7'd0);
        send_beat(ACT_PROBE, '{2'd3, 16'h4321, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF},
                  8'd0, 8'h00, 5'h00, 3'h0, 7'd0);
        send_beat(ACT_PROBE, '{2'd0, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00},
                  8'd0, 8'hA5, 5'h0A, 3'h5, 7'd0);
        send_beat(ACT_PROBE, '{2'd1, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00},
                  8'd0, 8'd0, 5'd0, 3'd0, 7'd0);
        send_beat(ACT_READ, k, 8'd0, 8'd0, 5'd0, 3'd0, 7'd0);
        send_beat(ACT_READ, k, 8'd0, 8'd0, 5'd0, 3'd0, 7'd2);
        send_beat(ACT_READ, k, 8'd0, 8'd0, 5'd0, 3'd0, 7'd3);
        send_beat(ACT_CLEAR, k, 8'd0, 8'd0, 5'd0, 3'd0, 7'd0);
        send_beat(ACT_READ, k, 8'd0, 8'd0, 5'd0, 3'd0, 7'd0);

        // Fill the descriptor table past full, then the binding store past full.
        for (int i = 0; i < 62; i++)
            send_beat(ACT_REGISTER, pick_key(1), 8'($urandom_range(0, 3)),
                      8'd0, 5'd0, 3'd0, 7'd0);
        send_beat(ACT_REGISTER, k, 8'd1, 8'd0, 5'd0, 3'd0, 7'd0);
        for (int i = 0; i < 130; i++)
            send_beat(ACT_PROBE, k, 8'd0, 8'($urandom), 5'($urandom), 3'($urandom), 7'd0);
        send_beat(ACT_READ, k, 8'd0, 8'd0, 5'd0, 3'd0, 7'd127);
        send_beat(ACT_CLEAR, k, 8'd0, 8'd0, 5'd0, 3'd0, 7'd0);

        // Random phases, each with its own wildcard codes, on the same full table.
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            write_reg(CFG_WILDCARD_WIDE[0], ph == 3 ? 16'($urandom) : wide_set[ph]);
            write_reg(CFG_WILDCARD_NARROW[0], {8'h00, narrow_set[ph]});
            for (int i = 0; i < 310; i++)
            begin
                random_beat();
                if (i == 135 && ph == 1) drain();
            end
            // No reset is applied between phases, so later phases keep probing a full table.
        end

        drain();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
